// ===== sv/dwrs_pkg.sv =====
// shared widths, constants and types for the dual window relay scheduler
`timescale 1ns / 1ps

package dwrs_pkg;

  localparam int RELAY_COUNT  = 4;
  localparam int WIN_REGS     = 4;
  localparam int LANES        = (RELAY_COUNT < WIN_REGS) ? RELAY_COUNT : WIN_REGS;
  localparam int LEVEL_W      = 4;
  localparam int HOUR_W       = 5;
  localparam int MINUTE_W     = 6;
  localparam int T_W          = 11;
  localparam int WIN_W        = 4 * T_W;
  localparam int MIN_PER_HOUR = 60;

  // apb side
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_WIN_ONE   = 3'd0,
    REG_WIN_TWO   = 3'd1,
    REG_WIN_THREE = 3'd2,
    REG_WIN_FOUR  = 3'd3,
    REG_STARTUP   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    DRIVE_NONE = 2'd0,
    DRIVE_LOW  = 2'd1,
    DRIVE_HIGH = 2'd2
  } drive_t;

  typedef logic [T_W-1:0]     mod_t;
  typedef logic [LEVEL_W-1:0] levels_t;

endpackage

// ===== sv/dwrs_if.sv =====
// valid/ready channels for clock ticks and relay results
`timescale 1ns / 1ps

interface dwrs_tick_if import dwrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour_now;
  logic [MINUTE_W-1:0] minute_now;

  modport source (output valid, output hour_now, output minute_now, input ready);
  modport sink   (input valid, input hour_now, input minute_now, output ready);
endinterface

interface dwrs_result_if import dwrs_pkg::*; ();
  logic    valid;
  logic    ready;
  levels_t relay_levels;
  levels_t relays_acted;

  modport source (output valid, output relay_levels, output relays_acted, input ready);
  modport sink   (input valid, input relay_levels, input relays_acted, output ready);
endinterface

// ===== sv/dual_window_relay_scheduler_unit.sv =====
// top level: window registers, tick register, relay decision and result register
`timescale 1ns / 1ps

// path: a tick word passes the tick register, then the result register, to the output
// one tick word per cycle unless stalled; the held levels update in the result stage
// stalls: a full result register that is not taken holds the tick register behind it
// reset (rst, synchronous): clears valids, held levels, the startup flag and all
// configuration registers; no clearing pass
module dual_window_relay_scheduler_unit import dwrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  dwrs_tick_if.sink          tick,
  dwrs_result_if.source      result
);

  logic [WIN_W-1:0] win [WIN_REGS];
  levels_t          startup;
  reg_idx_t         idx;
  logic             wr_en;

  logic    s1_valid;
  mod_t    s1_t;
  logic    advance;
  logic    loaded;
  levels_t held;
  levels_t base;
  levels_t levels_next;
  levels_t acted_next;

  function automatic drive_t decide(input mod_t t, input mod_t on1, input mod_t off1,
                                    input mod_t on2, input mod_t off2);
    drive_t d;
    logic   wrap1, wrap2, first1, first2, in1, in2, past1, past2;
    d      = DRIVE_NONE;
    wrap1  = on1 > off1;
    wrap2  = on2 > off2;
    first1 = on1 < on2;
    first2 = on2 < on1;
    in1    = (t >= on1) && (t < off1);
    in2    = (t >= on2) && (t < off2);
    past1  = (t > on1) && (t >= off1);
    past2  = (t > on2) && (t >= off2);
    if ((on1 == off1) && (on2 == off2)) begin
      d = DRIVE_NONE;
    end else if (wrap1 && !wrap2) begin
      d = (t < off1) ? DRIVE_HIGH : DRIVE_LOW;
      if (in2) d = DRIVE_HIGH;
      if (t >= on1) d = DRIVE_HIGH;
    end else if (wrap2 && !wrap1) begin
      d = (t < off2) ? DRIVE_HIGH : DRIVE_LOW;
      if (in1) d = DRIVE_HIGH;
      if (t >= on2) d = DRIVE_HIGH;
    end else if (!wrap1 && !wrap2) begin
      // later rules override earlier ones
      if ((t < on1) && (t < on2)) d = DRIVE_LOW;
      if (first1 && in1) d = DRIVE_HIGH;
      if (first1 && past1) d = DRIVE_LOW;
      if (first2 && in2) d = DRIVE_HIGH;
      if (first2 && past2) d = DRIVE_LOW;
      if (first1 && in2) d = DRIVE_HIGH;
      if (first1 && past2) d = DRIVE_LOW;
      if (first2 && in1) d = DRIVE_HIGH;
      if (first2 && past1) d = DRIVE_LOW;
      if ((t >= off1) && (t >= off2)) d = DRIVE_LOW;
    end
    return d;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_REGS; i++) win[i] <= '0;
      startup <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIN_ONE:   win[0]  <= pwdata[WIN_W-1:0];
        REG_WIN_TWO:   win[1]  <= pwdata[WIN_W-1:0];
        REG_WIN_THREE: win[2]  <= pwdata[WIN_W-1:0];
        REG_WIN_FOUR:  win[3]  <= pwdata[WIN_W-1:0];
        REG_STARTUP:   startup <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIN_ONE:   prdata = DATA_W'(win[0]);
      REG_WIN_TWO:   prdata = DATA_W'(win[1]);
      REG_WIN_THREE: prdata = DATA_W'(win[2]);
      REG_WIN_FOUR:  prdata = DATA_W'(win[3]);
      REG_STARTUP:   prdata = DATA_W'(startup);
      default:       prdata = '0;
    endcase
  end

  // tick register holds the minute of day
  assign advance    = !result.valid || result.ready;
  assign tick.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_t <= T_W'(tick.hour_now) * T_W'(MIN_PER_HOUR) + T_W'(tick.minute_now);
    end
  end

  // relay decisions, one lane per window register
  assign base = loaded ? held : startup;

  always_comb begin
    levels_next = base;
    acted_next  = '0;
    for (int i = 0; i < LANES; i++) begin
      unique case (decide(s1_t, win[i][T_W-1:0], win[i][2*T_W-1:T_W],
                          win[i][3*T_W-1:2*T_W], win[i][4*T_W-1:3*T_W]))
        DRIVE_HIGH: begin
          levels_next[i] = 1'b1;
          acted_next[i]  = 1'b1;
        end
        DRIVE_LOW: begin
          levels_next[i] = 1'b0;
          acted_next[i]  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      loaded       <= 1'b0;
      held         <= '0;
    end else if (advance) begin
      result.valid <= s1_valid;
      if (s1_valid) begin
        loaded <= 1'b1;
        held   <= levels_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.relay_levels <= levels_next;
      result.relays_acted <= acted_next;
    end
  end

endmodule
